/* rtl/core/sps_vui_colour_parser_assert.svh */
// Assertion helpers for the SPS colour reader.
`ifndef SPS_VUI_COLOUR_PARSER_ASSERT_SVH
`define SPS_VUI_COLOUR_PARSER_ASSERT_SVH

// prop must hold at every clock edge outside reset
`define SVCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// cond must never be true outside reset
`define SVCP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/core/svcp_pkg.sv */
package svcp_pkg;

  localparam int StepW = 6;

  localparam logic [StepW-1:0] ST_PROFILE    = 6'd0;
  localparam logic [StepW-1:0] ST_CONSTR     = 6'd1;
  localparam logic [StepW-1:0] ST_LEVEL      = 6'd2;
  localparam logic [StepW-1:0] ST_SPS_ID     = 6'd3;
  localparam logic [StepW-1:0] ST_CHROMA     = 6'd4;
  localparam logic [StepW-1:0] ST_SEP_PLANE  = 6'd5;
  localparam logic [StepW-1:0] ST_DEPTH_L    = 6'd6;
  localparam logic [StepW-1:0] ST_DEPTH_C    = 6'd7;
  localparam logic [StepW-1:0] ST_QP_BYPASS  = 6'd8;
  localparam logic [StepW-1:0] ST_SCALING    = 6'd9;
  localparam logic [StepW-1:0] ST_LOG2_FRAME = 6'd10;
  localparam logic [StepW-1:0] ST_POC_TYPE   = 6'd11;
  localparam logic [StepW-1:0] ST_POC_LSB    = 6'd12;
  localparam logic [StepW-1:0] ST_DELTA_ZERO = 6'd13;
  localparam logic [StepW-1:0] ST_OFF_NONREF = 6'd14;
  localparam logic [StepW-1:0] ST_OFF_TB     = 6'd15;
  localparam logic [StepW-1:0] ST_POC_CYCLE  = 6'd16;
  localparam logic [StepW-1:0] ST_POC_OFF    = 6'd17;
  localparam logic [StepW-1:0] ST_MAX_REF    = 6'd18;
  localparam logic [StepW-1:0] ST_GAPS       = 6'd19;
  localparam logic [StepW-1:0] ST_WIDTH      = 6'd20;
  localparam logic [StepW-1:0] ST_HEIGHT     = 6'd21;
  localparam logic [StepW-1:0] ST_FRAME_MBS  = 6'd22;
  localparam logic [StepW-1:0] ST_MBAFF      = 6'd23;
  localparam logic [StepW-1:0] ST_DIRECT8    = 6'd24;
  localparam logic [StepW-1:0] ST_CROP_FLAG  = 6'd25;
  localparam logic [StepW-1:0] ST_CROP       = 6'd26;
  localparam logic [StepW-1:0] ST_VUI_FLAG   = 6'd27;
  localparam logic [StepW-1:0] ST_AR_FLAG    = 6'd28;
  localparam logic [StepW-1:0] ST_AR_IDC     = 6'd29;
  localparam logic [StepW-1:0] ST_SAR        = 6'd30;
  localparam logic [StepW-1:0] ST_OVS_FLAG   = 6'd31;
  localparam logic [StepW-1:0] ST_OVS_APPR   = 6'd32;
  localparam logic [StepW-1:0] ST_VST_FLAG   = 6'd33;
  localparam logic [StepW-1:0] ST_VFORMAT    = 6'd34;
  localparam logic [StepW-1:0] ST_RANGE      = 6'd35;
  localparam logic [StepW-1:0] ST_COL_FLAG   = 6'd36;
  localparam logic [StepW-1:0] ST_COLOUR     = 6'd37;
  localparam logic [StepW-1:0] ST_DONE_NOCOL = 6'd38;
  localparam logic [StepW-1:0] ST_DONE_COL   = 6'd39;

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [7:0] EPB_BYTE     = 8'h03;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic             stopped;
    logic             overran;
    logic             range_seen;
    logic [23:0]      colour_codes;
  } svcp_status_t;

  // fixed field width per step; 0 marks an Exp-Golomb field
  function automatic logic [5:0] field_len(input logic [StepW-1:0] s);
    logic [5:0] r;
    unique case (s)
      ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_AR_IDC: r = 6'd8;
      ST_SEP_PLANE, ST_QP_BYPASS, ST_SCALING, ST_DELTA_ZERO, ST_GAPS,
      ST_FRAME_MBS, ST_MBAFF, ST_DIRECT8, ST_CROP_FLAG, ST_VUI_FLAG,
      ST_AR_FLAG, ST_OVS_FLAG, ST_OVS_APPR, ST_VST_FLAG, ST_RANGE,
      ST_COL_FLAG: r = 6'd1;
      ST_SAR:      r = 6'd32;
      ST_VFORMAT:  r = 6'd3;
      ST_COLOUR:   r = 6'd24;
      default:     r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    logic r;
    case (p)
      8'd44, 8'd83, 8'd86, 8'd100, 8'd110, 8'd118, 8'd122,
      8'd128, 8'd134, 8'd135, 8'd138, 8'd139, 8'd244: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] map_primaries(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      8'd1:       r = 2'd1;
      8'd5, 8'd6: r = 2'd2;
      8'd9:       r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] map_transfer(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      8'd1, 8'd6, 8'd14, 8'd15: r = 2'd1;
      8'd5, 8'd8:               r = 2'd2;
      8'd16:                    r = 2'd3;
      default:                  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] map_matrix(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      8'd5, 8'd6:  r = 2'd1;
      8'd9, 8'd10: r = 2'd2;
      default:     r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/sps_vui_colour_parser.sv */
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | data_byte_i, last_byte_i
// out     | output    | out_valid_o/out_ready_i | colour_present_o, full_range_o,
//         |           |                       | primaries_kind_o, transfer_kind_o,
//         |           |                       | matrix_kind_o
// cfg     | input     | cfg_we_i              | cfg_data_i (codec_is_h264)
//
// Each payload byte is accepted, then walked through the bit-serial SPS walker
// (one bit per cycle from the byte shift register), then finished in a wrap-up
// cycle; no new byte is taken until then. Header and dropped emulation-prevention
// bytes skip the walk (accept plus wrap-up).
// The last byte of a NAL loads the result register in its wrap-up cycle; if the
// previous result is still waiting there the block holds until it is taken.
// Reset clears all per-NAL control state but not the result payload; codec_is_h264 resets to 1.
`include "sps_vui_colour_parser_assert.svh"

module sps_vui_colour_parser import svcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       colour_present_o,
  output logic       full_range_o,
  output logic [1:0] primaries_kind_o,
  output logic [1:0] transfer_kind_o,
  output logic [1:0] matrix_kind_o
);

  logic       codec_q;
  logic [2:0] raw_cnt_q, raw_cnt_d;
  logic [1:0] zrun_q, zrun_d;
  logic [7:0] sh_q, sh_d;
  logic [3:0] bcnt_q, bcnt_d;
  logic       busy_q, busy_d;
  logic       last_q, last_d;
  logic       ov_q, ov_d;
  logic       cp_q, cp_d, fr_q, fr_d;
  logic [1:0] pk_q, pk_d, tk_q, tk_d, mk_q, mk_d;

  logic         in_acc;
  logic         hdr_stop;
  logic         emit;
  logic         nal_ok;
  svcp_status_t st;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // wrap-up: all bits walked, last byte needs a free result slot
  assign emit = busy_q && (bcnt_q == 4'd0) && last_q && (!ov_q || out_ready_i);

  assign nal_ok = codec_q && (raw_cnt_q == 3'd4) && !st.stopped && !st.overran &&
                  (st.step >= ST_AR_FLAG);

  always_comb begin
    raw_cnt_d = raw_cnt_q; zrun_d = zrun_q; sh_d = sh_q; bcnt_d = bcnt_q;
    busy_d = busy_q; last_d = last_q; ov_d = ov_q;
    cp_d = cp_q; fr_d = fr_q; pk_d = pk_q; tk_d = tk_q; mk_d = mk_q;
    hdr_stop = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    if (in_acc) begin
      busy_d = 1'b1;
      last_d = last_byte_i;
      sh_d   = data_byte_i;
      bcnt_d = 4'd0;
      if (raw_cnt_q == 3'd0) begin
        hdr_stop = (data_byte_i[4:0] != NAL_TYPE_SPS);
      end else if (zrun_q == 2'd2 && data_byte_i == EPB_BYTE) begin
        zrun_d = 2'd0;
      end else begin
        if (data_byte_i == 8'd0) zrun_d = (zrun_q == 2'd2) ? 2'd2 : zrun_q + 2'd1;
        else zrun_d = 2'd0;
        bcnt_d = 4'd8;
      end
      if (raw_cnt_q != 3'd4) raw_cnt_d = raw_cnt_q + 3'd1;
    end else if (busy_q) begin
      if (bcnt_q != 4'd0) begin
        sh_d   = {sh_q[6:0], 1'b0};
        bcnt_d = bcnt_q - 4'd1;
      end else if (!last_q) begin
        busy_d = 1'b0;
      end else if (emit) begin
        busy_d    = 1'b0;
        ov_d      = 1'b1;
        raw_cnt_d = 3'd0;
        zrun_d    = 2'd0;
        cp_d = 1'b0; fr_d = 1'b0; pk_d = 2'd0; tk_d = 2'd0; mk_d = 2'd0;
        if (nal_ok) begin
          fr_d = st.range_seen;
          if (st.step == ST_DONE_COL) begin
            cp_d = 1'b1;
            pk_d = map_primaries(st.colour_codes[23:16]);
            tk_d = map_transfer(st.colour_codes[15:8]);
            mk_d = map_matrix(st.colour_codes[7:0]);
          end
        end
      end
    end
  end

  svcp_bit_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (emit),
    .stop_i   (hdr_stop),
    .bit_en_i (busy_q && bcnt_q != 4'd0),
    .bit_i    (sh_q[7]),
    .status_o (st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q   <= 1'b1;
      raw_cnt_q <= '0;
      zrun_q    <= '0;
      bcnt_q    <= '0;
      busy_q    <= 1'b0;
      last_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (cfg_we_i) codec_q <= cfg_data_i;
      raw_cnt_q <= raw_cnt_d;
      zrun_q    <= zrun_d;
      bcnt_q    <= bcnt_d;
      busy_q    <= busy_d;
      last_q    <= last_d;
      ov_q      <= ov_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    cp_q <= cp_d;
    fr_q <= fr_d;
    pk_q <= pk_d;
    tk_q <= tk_d;
    mk_q <= mk_d;
  end

  assign out_valid_o      = ov_q;
  assign colour_present_o = cp_q;
  assign full_range_o     = fr_q;
  assign primaries_kind_o = pk_q;
  assign transfer_kind_o  = tk_q;
  assign matrix_kind_o    = mk_q;

  `SVCP_ASSERT(a_clear_after_emit, clk_i, rst_ni, emit |=> (st.step == ST_PROFILE && !st.stopped && !st.overran), "parser not cleared after result")
  `SVCP_ASSERT_NEVER(a_bits_when_idle, clk_i, rst_ni, (bcnt_q != 4'd0) && !busy_q, "bit counter running while idle")
  `SVCP_ASSERT(a_result_from_last, clk_i, rst_ni, $rose(out_valid_o) |-> $past(busy_q && last_q), "result without a last byte")

endmodule

/* rtl/core/svcp_bit_parser.sv */
// Walks the SPS syntax one bit per cycle while bit_en_i is high.
module svcp_bit_parser import svcp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clear_i,
  input  logic         stop_i,
  input  logic         bit_en_i,
  input  logic         bit_i,
  output svcp_status_t status_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [31:0]      fs_q, fs_d;
  logic [5:0]       bl_q, bl_d;
  logic [5:0]       lz_q, lz_d;
  logic [31:0]      skip_q, skip_d;
  logic [7:0]       prof_q, prof_d;
  logic             stop_q, stop_d;
  logic             ovr_q, ovr_d;
  logic             rng_q, rng_d;
  logic [23:0]      col_q, col_d;

  logic [5:0]       flen;
  logic             eg;
  logic [31:0]      fs_n;
  logic [5:0]       bl_n;
  logic [31:0]      val;
  logic             fin;
  logic             go;
  logic [StepW-1:0] nxt;
  logic [31:0]      sk_dec;

  always_comb begin
    step_d = step_q; fs_d = fs_q; bl_d = bl_q; lz_d = lz_q; skip_d = skip_q;
    prof_d = prof_q; stop_d = stop_q; ovr_d = ovr_q; rng_d = rng_q; col_d = col_q;
    flen   = field_len(step_q);
    eg     = (flen == 6'd0);
    fs_n   = {fs_q[30:0], bit_i};
    bl_n   = bl_q - 6'd1;
    val    = '0;
    fin    = 1'b0;
    go     = 1'b0;
    nxt    = step_q;
    sk_dec = skip_q - 32'd1;
    if (clear_i) begin
      step_d = ST_PROFILE; fs_d = '0; bl_d = field_len(ST_PROFILE); lz_d = '0;
      skip_d = '0; prof_d = '0; stop_d = 1'b0; ovr_d = 1'b0; rng_d = 1'b0;
      col_d = '0;
    end else begin
      if (stop_i) stop_d = 1'b1;
      if (bit_en_i && step_q < ST_DONE_NOCOL && !stop_q && !ovr_q) begin
        if (!eg || bl_q != 6'd0) begin
          fs_d = fs_n;
          bl_d = bl_n;
          if (bl_n == 6'd0) begin
            fin = 1'b1;
            // suffix register starts at one, so code value is fs - 1
            val = eg ? fs_n - 32'd1 : fs_n;
          end
        end else if (!bit_i) begin
          lz_d = lz_q + 6'd1;
          if (lz_q == 6'd31) ovr_d = 1'b1;
        end else if (lz_q == 6'd0) begin
          fin = 1'b1;
        end else begin
          bl_d = lz_q;
          fs_d = 32'd1;
        end
      end
      if (fin) begin
        go = 1'b1;
        unique case (step_q)
          ST_PROFILE:    begin prof_d = val[7:0]; nxt = ST_CONSTR; end
          ST_CONSTR:     nxt = ST_LEVEL;
          ST_LEVEL:      nxt = ST_SPS_ID;
          ST_SPS_ID:     nxt = high_profile(prof_q) ? ST_CHROMA : ST_LOG2_FRAME;
          ST_CHROMA:     nxt = (val == 32'd3) ? ST_SEP_PLANE : ST_DEPTH_L;
          ST_SEP_PLANE:  nxt = ST_DEPTH_L;
          ST_DEPTH_L:    nxt = ST_DEPTH_C;
          ST_DEPTH_C:    nxt = ST_QP_BYPASS;
          ST_QP_BYPASS:  nxt = ST_SCALING;
          ST_SCALING: begin
            if (val[0]) begin
              stop_d = 1'b1; go = 1'b0;
            end else begin
              nxt = ST_LOG2_FRAME;
            end
          end
          ST_LOG2_FRAME: nxt = ST_POC_TYPE;
          ST_POC_TYPE: begin
            if (val == 32'd0) nxt = ST_POC_LSB;
            else if (val == 32'd1) nxt = ST_DELTA_ZERO;
            else nxt = ST_MAX_REF;
          end
          ST_POC_LSB:    nxt = ST_MAX_REF;
          ST_DELTA_ZERO: nxt = ST_OFF_NONREF;
          ST_OFF_NONREF: nxt = ST_OFF_TB;
          ST_OFF_TB:     nxt = ST_POC_CYCLE;
          ST_POC_CYCLE: begin
            skip_d = val;
            nxt = (val != 32'd0) ? ST_POC_OFF : ST_MAX_REF;
          end
          ST_POC_OFF: begin
            skip_d = sk_dec;
            nxt = (sk_dec != 32'd0) ? ST_POC_OFF : ST_MAX_REF;
          end
          ST_MAX_REF:    nxt = ST_GAPS;
          ST_GAPS:       nxt = ST_WIDTH;
          ST_WIDTH:      nxt = ST_HEIGHT;
          ST_HEIGHT:     nxt = ST_FRAME_MBS;
          ST_FRAME_MBS:  nxt = val[0] ? ST_DIRECT8 : ST_MBAFF;
          ST_MBAFF:      nxt = ST_DIRECT8;
          ST_DIRECT8:    nxt = ST_CROP_FLAG;
          ST_CROP_FLAG: begin
            if (val[0]) begin
              skip_d = 32'd4; nxt = ST_CROP;
            end else begin
              nxt = ST_VUI_FLAG;
            end
          end
          ST_CROP: begin
            skip_d = sk_dec;
            nxt = (sk_dec != 32'd0) ? ST_CROP : ST_VUI_FLAG;
          end
          ST_VUI_FLAG: begin
            if (val[0]) begin
              nxt = ST_AR_FLAG;
            end else begin
              stop_d = 1'b1; go = 1'b0;
            end
          end
          ST_AR_FLAG:    nxt = val[0] ? ST_AR_IDC : ST_OVS_FLAG;
          ST_AR_IDC:     nxt = (val[7:0] == 8'd255) ? ST_SAR : ST_OVS_FLAG;
          ST_SAR:        nxt = ST_OVS_FLAG;
          ST_OVS_FLAG:   nxt = val[0] ? ST_OVS_APPR : ST_VST_FLAG;
          ST_OVS_APPR:   nxt = ST_VST_FLAG;
          ST_VST_FLAG:   nxt = val[0] ? ST_VFORMAT : ST_DONE_NOCOL;
          ST_VFORMAT:    nxt = ST_RANGE;
          ST_RANGE:      begin rng_d = val[0]; nxt = ST_COL_FLAG; end
          ST_COL_FLAG:   nxt = val[0] ? ST_COLOUR : ST_DONE_NOCOL;
          ST_COLOUR:     begin col_d = val[23:0]; nxt = ST_DONE_COL; end
          default:       go = 1'b0;
        endcase
      end
      if (go) begin
        step_d = nxt;
        fs_d   = '0;
        lz_d   = '0;
        bl_d   = field_len(nxt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_PROFILE;
      fs_q   <= '0;
      bl_q   <= field_len(ST_PROFILE);
      lz_q   <= '0;
      skip_q <= '0;
      prof_q <= '0;
      stop_q <= 1'b0;
      ovr_q  <= 1'b0;
      rng_q  <= 1'b0;
      col_q  <= '0;
    end else begin
      step_q <= step_d;
      fs_q   <= fs_d;
      bl_q   <= bl_d;
      lz_q   <= lz_d;
      skip_q <= skip_d;
      prof_q <= prof_d;
      stop_q <= stop_d;
      ovr_q  <= ovr_d;
      rng_q  <= rng_d;
      col_q  <= col_d;
    end
  end

  assign status_o.step         = step_q;
  assign status_o.stopped      = stop_q;
  assign status_o.overran      = ovr_q;
  assign status_o.range_seen   = rng_q;
  assign status_o.colour_codes = col_q;

endmodule
